// ----- src/rau_pkg.sv -----
// ============================================================================
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ============================================================================
package rau_pkg;

    localparam int MAG_W   = 32;                // operand magnitude width
    localparam int PROD_W  = 64;                // full product width
    localparam int DIV_STEPS = 64;              // quotient bits per division
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_CMP = 3'd4;
    localparam logic [2:0] ACT_NEG = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GCD,
        S_DIV,
        S_DIVX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_less;
        logic               is_equal;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       comb;
        logic       gcd_step;
        logic       div_init;
        logic       div_sel;    // 0: numerator pass, 1: denominator pass
        logic       div_step;
        logic       div_save;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic early;     // result known without reduction
        logic nzero;     // numerator is zero
        logic gcd_done;
        logic out_free;
    } t_sts;

endpackage

// ----- src/rational_arithmetic_unit.sv -----
// ============================================================================
// rational_arithmetic_unit
// Add, subtract, multiply, divide, compare or negate two fractions, with the
// result reduced by its gcd and given over a positive denominator.
// ============================================================================
// One word in, one word out. An operation ends early, without reduction, for
// compare, a zero denominator or an unknown action, and skips the gcd and the
// divisions when its numerator is zero. Otherwise its time is set by the
// binary gcd loop on the 64-bit numerator and denominator and by the 64-step
// restoring divider, run once for the numerator and once for the
// denominator. The unit goes back to idle on the hand-off of the result and
// takes the next word from there.
// Only one operation is in flight; o_stall is high from the accept until the
// result moves into the output register. A finished word may wait there
// while the next operation is accepted. WORD_BITS sets the range check
// for overflow status; the result fields carry the low bits.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_cmd cmd;
    t_sts sts;
    logic busy;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rau_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .i_stall (i_stall),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    assign o_stall = busy;

    // an accepted word keeps the input side closed next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not closed after accept");

    // error results are 0/1 with no flags
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |->
        o_data.res_num == 32'sd0 && o_data.res_den == 31'd1 &&
        !o_data.is_less && !o_data.is_equal)
        else $error("error word not cleared");

    // denominator never zero
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.res_den != 31'd0)
        else $error("zero denominator out");

    // less and equal are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.is_less && o_data.is_equal))
        else $error("less and equal both set");

    // a new output word only loads when the old one is gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !o_valid || !i_stall)
        else $error("output word overwritten");

endmodule

// ----- src/rau_ctrl.sv -----
// ============================================================================
// rau_ctrl
// Sequencer: multiply, combine, gcd, two divisions, hand off result.
// ============================================================================
module rau_ctrl import rau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.mul_sel = r_cnt[1:0];
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = i_sts.early ? S_DONE : S_GCD;
            end
            S_GCD: begin
                if (i_sts.nzero) begin
                    n_state = S_DONE;
                end else if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_sel          = 1'b0;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.div_save = 1'b1;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- src/rau_dp.sv -----
// ============================================================================
// rau_dp
// Datapath: sign folding, shared multiplier, binary gcd, restoring divider,
// range check and output word register.
// ============================================================================
module rau_dp import rau_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_data,
    input  t_cmd i_cmd,
    input  logic i_stall,
    output t_sts o_sts,
    output logic o_valid,
    output t_out o_data
);

    localparam logic [PROD_W:0] LIM = (PROD_W+1)'(1) << (WORD_BITS - 1);

    function automatic logic [MAG_W-1:0] f_mag(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [2:0]        r_act;
    logic [MAG_W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic              r_as, r_bs;
    logic              r_early;
    logic [1:0]        r_est;
    logic [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic              r_less, r_eq, r_nneg;
    logic [PROD_W-1:0] r_nmag, r_dmag;
    logic [PROD_W-1:0] r_x, r_y;
    logic [CNT_W-1:0]  r_k;
    logic [PROD_W-1:0] r_rem, r_quo, r_dvs;
    logic              r_ovalid;
    t_out              r_out;

    // load decode
    logic [MAG_W-1:0] ld_an, ld_ad, ld_bn, ld_bd;
    logic             ld_early;
    logic [1:0]       ld_est;

    always_comb begin
        ld_an    = f_mag(i_data.a_num);
        ld_ad    = f_mag(i_data.a_den);
        ld_bn    = f_mag(i_data.b_num);
        ld_bd    = f_mag(i_data.b_den);
        ld_early = 1'b0;
        ld_est   = ST_OK;
        if (!(i_data.action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_CMP,
                                    ACT_NEG})) begin
            ld_early = 1'b1;
        end else if (ld_ad == '0 || (i_data.action != ACT_NEG && ld_bd == '0) ||
                     (i_data.action == ACT_DIV && ld_bn == '0)) begin
            ld_early = 1'b1;
            ld_est   = ST_DIV0;
        end else if (i_data.action == ACT_CMP) begin
            ld_early = 1'b1;
        end
    end

    // shared multiplier, one product per cycle
    logic [MAG_W-1:0]  mx, my;
    logic [PROD_W-1:0] prod;

    always_comb begin
        case (i_cmd.mul_sel)
            2'd0: begin
                mx = r_an;
                my = (r_act == ACT_MUL) ? r_bn :
                     (r_act == ACT_NEG) ? MAG_W'(1) : r_bd;
            end
            2'd1: begin
                mx = r_bn;
                my = (r_act inside {ACT_ADD, ACT_SUB, ACT_CMP}) ? r_ad : '0;
            end
            default: begin
                mx = r_ad;
                my = (r_act == ACT_DIV) ? r_bn :
                     (r_act == ACT_NEG) ? MAG_W'(1) : r_bd;
            end
        endcase
        prod = PROD_W'(mx) * PROD_W'(my);
    end

    // combine products into signed numerator
    logic              sg0, sg1;
    logic [PROD_W:0]   s0, s1, sum, nabs;

    always_comb begin
        sg0  = r_as ^ ((r_act == ACT_MUL || r_act == ACT_DIV) ? r_bs : 1'b0)
                    ^ (r_act == ACT_NEG);
        sg1  = r_bs ^ (r_act == ACT_SUB);
        s0   = sg0 ? -{1'b0, r_p0} : {1'b0, r_p0};
        s1   = sg1 ? -{1'b0, r_p1} : {1'b0, r_p1};
        sum  = s0 + s1;
        nabs = sum[PROD_W] ? -sum : sum;
    end

    // gcd divisor and divider step
    logic [PROD_W-1:0] g_c;
    logic [PROD_W:0]   dv_t;
    logic              dv_ge;

    assign g_c   = r_x << r_k;
    assign dv_t  = {r_rem, r_quo[PROD_W-1]};
    assign dv_ge = (dv_t >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_data.action;
            r_an    <= ld_an;
            r_ad    <= ld_ad;
            r_bn    <= ld_bn;
            r_bd    <= ld_bd;
            r_as    <= i_data.a_num[MAG_W-1] ^ i_data.a_den[MAG_W-1];
            r_bs    <= i_data.b_num[MAG_W-1] ^ i_data.b_den[MAG_W-1];
            r_early <= ld_early;
            r_est   <= ld_est;
        end
        if (i_cmd.mul_step) begin
            case (i_cmd.mul_sel)
                2'd0:    r_p0 <= prod;
                2'd1:    r_p1 <= prod;
                default: r_p2 <= prod;
            endcase
        end
        if (i_cmd.comb) begin
            r_less <= $signed(s0) < $signed(s1);
            r_eq   <= (s0 == s1);
            r_nneg <= sum[PROD_W];
            r_nmag <= nabs[PROD_W-1:0];
            r_dmag <= r_p2;
            r_x    <= nabs[PROD_W-1:0];
            r_y    <= r_p2;
            r_k    <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_cmd.div_init) begin
            r_dvs <= g_c;
            r_quo <= r_nmag;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= dv_ge ? PROD_W'(dv_t - {1'b0, r_dvs}) : dv_t[PROD_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], dv_ge};
        end
        if (i_cmd.div_save) begin
            if (!i_cmd.div_sel) begin
                r_nmag <= r_quo;
                r_quo  <= r_dmag;
                r_rem  <= '0;
            end else begin
                r_dmag <= r_quo;
            end
        end
    end

    // result word
    t_out              res;
    logic [PROD_W-1:0] nsig;

    always_comb begin
        res         = '0;
        res.res_den = 31'd1;
        res.status  = ST_OK;
        nsig        = r_nneg ? -r_nmag : r_nmag;
        if (r_early) begin
            res.status = r_est;
            if (r_act == ACT_CMP && r_est == ST_OK) begin
                res.is_less  = r_less;
                res.is_equal = r_eq;
            end
        end else if (r_nmag != '0) begin
            if ({1'b0, r_dmag} > LIM - 1'b1 || {1'b0, r_nmag} > LIM ||
                (!r_nneg && {1'b0, r_nmag} > LIM - 1'b1)) begin
                res.status = ST_OVF;
            end else begin
                res.res_num = nsig[31:0];
                res.res_den = r_dmag[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_sts.early    = r_early;
    assign o_sts.nzero    = (r_nmag == '0);
    assign o_sts.gcd_done = (r_x == r_y);
    assign o_sts.out_free = !r_ovalid || !i_stall;
    assign o_valid        = r_ovalid;
    assign o_data         = r_out;

endmodule
